// ----- hw/rtl/clcd_pkg.sv -----
// shared types, register indexes, phase codes and constants for the character
// display sequencer; no dependencies
package clcd_pkg;

  localparam int WAIT_BITS  = 16;
  localparam int CFG_BITS   = 16;
  localparam int PULSE_BITS = 8;
  localparam int SKIP_STEPS = 4;

  typedef logic [WAIT_BITS-1:0] wait_t;
  typedef logic [CFG_BITS-1:0]  dur_t;

  // action codes carried with each input item
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_INIT   = 3'd1;
  localparam logic [2:0] ACT_CMD    = 3'd2;
  localparam logic [2:0] ACT_DATA   = 3'd3;
  localparam logic [2:0] ACT_CURSOR = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_POWER_UP   = 3'd0;
  localparam logic [2:0] REG_INIT_LONG  = 3'd1;
  localparam logic [2:0] REG_INIT_SHORT = 3'd2;
  localparam logic [2:0] REG_PULSE_HIGH = 3'd3;
  localparam logic [2:0] REG_PULSE_GAP  = 3'd4;
  localparam logic [2:0] REG_EXEC_WAIT  = 3'd5;
  localparam logic [2:0] REG_CLEAR_WAIT = 3'd6;

  // init byte index codes
  localparam logic [2:0] IDX_NONE       = 3'd0;
  localparam logic [2:0] IDX_FIRST      = 3'd1;
  localparam logic [2:0] IDX_LAST_SETUP = 3'd4;
  localparam logic [2:0] IDX_CLEAR      = 3'd5;

  localparam logic [7:0] ROW0_BASE    = 8'h80;
  localparam logic [7:0] ROW1_BASE    = 8'hC0;
  localparam logic [7:0] CLEAR_CMD    = 8'h01;
  localparam logic [3:0] NIB_INIT     = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT = 4'h2;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_PWR     = 5'd1,
    PH_I1_HIGH = 5'd2,
    PH_I1_GAP  = 5'd3,
    PH_I1_WAIT = 5'd4,
    PH_I2_HIGH = 5'd5,
    PH_I2_GAP  = 5'd6,
    PH_I2_WAIT = 5'd7,
    PH_I3_HIGH = 5'd8,
    PH_I3_GAP  = 5'd9,
    PH_I3_WAIT = 5'd10,
    PH_I4_HIGH = 5'd11,
    PH_I4_GAP  = 5'd12,
    PH_HI_HIGH = 5'd13,
    PH_HI_GAP  = 5'd14,
    PH_LO_HIGH = 5'd15,
    PH_LO_GAP  = 5'd16,
    PH_EXEC    = 5'd17,
    PH_CLEARW  = 5'd18
  } phase_t;

  typedef struct packed {
    dur_t                  power_up_wait;
    dur_t                  init_long_wait;
    dur_t                  init_short_wait;
    logic [PULSE_BITS-1:0] pulse_high;
    dur_t                  pulse_gap;
    dur_t                  exec_wait;
    dur_t                  clear_wait;
  } cfg_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] col;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       busy_res;
    logic [3:0] data_pins;
    logic       en_pin;
    logic       rs_pin;
  } res_t;

  // configuration bytes sent after the nibble handshake of init
  function automatic logic [7:0] setup_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h28;
      2'd1: b = 8'h0C;
      2'd2: b = 8'h06;
      2'd3: b = 8'h01;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  // saturate a register duration to the wait counter range
  function automatic wait_t clip_wait(input dur_t d);
    logic [CFG_BITS+WAIT_BITS-1:0] dx;
    logic [CFG_BITS+WAIT_BITS-1:0] mx;
    dx = (CFG_BITS+WAIT_BITS)'(d);
    mx = (CFG_BITS+WAIT_BITS)'({WAIT_BITS{1'b1}});
    return (dx > mx) ? WAIT_BITS'(mx) : WAIT_BITS'(dx);
  endfunction

endpackage

// ----- hw/rtl/clcd_seq.sv -----
// phase sequencer: state registers and next-state logic for one item per cycle
// while step_en is high; depends on clcd_pkg
module clcd_seq
  import clcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  phase_t     step_r, step_nxt;
  wait_t      wait_r, wait_nxt;
  logic [7:0] held_r, held_nxt;
  logic       rs_r, rs_nxt;
  logic       en_r, en_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       acc;
  logic       go;
  phase_t     p;
  dur_t       d;
  wait_t      dc;
  logic [2:0] ix_tmp;
  logic [7:0] hb_tmp;
  dur_t       ph_dur;

  assign ph_dur = (cfg.pulse_high == '0) ? dur_t'(1)
                                         : CFG_BITS'(cfg.pulse_high);

  // pins and duration of a phase
  function automatic dur_t phase_setup(input phase_t ph, input logic [7:0] hb,
                                       input cfg_t c, input dur_t pw,
                                       inout logic en, inout logic [3:0] nib);
    dur_t r;
    r = '0;
    unique case (ph)
      PH_PWR: r = c.power_up_wait;
      PH_I1_HIGH, PH_I2_HIGH, PH_I3_HIGH: begin
        en = 1'b1; nib = NIB_INIT; r = pw;
      end
      PH_I4_HIGH: begin
        en = 1'b1; nib = NIB_FOUR_BIT; r = pw;
      end
      PH_HI_HIGH: begin
        en = 1'b1; nib = hb[7:4]; r = pw;
      end
      PH_LO_HIGH: begin
        en = 1'b1; nib = hb[3:0]; r = pw;
      end
      PH_I1_GAP, PH_I2_GAP, PH_I3_GAP, PH_I4_GAP, PH_HI_GAP, PH_LO_GAP: begin
        en = 1'b0; r = c.pulse_gap;
      end
      PH_I1_WAIT: r = c.init_long_wait;
      PH_I2_WAIT, PH_I3_WAIT: r = c.init_short_wait;
      PH_EXEC: r = c.exec_wait;
      PH_CLEARW: r = c.clear_wait;
      default: r = '0;
    endcase
    return r;
  endfunction

  // successor phase, with init byte bookkeeping
  function automatic phase_t next_phase(input phase_t ph, input logic [2:0] ix_in,
                                        input logic [7:0] hb_in,
                                        output logic [2:0] ix_out,
                                        output logic [7:0] hb_out);
    phase_t n;
    ix_out = ix_in;
    hb_out = hb_in;
    priority if (ph == PH_I4_GAP) begin
      ix_out = IDX_FIRST;
      hb_out = setup_byte(2'd0);
      n = PH_HI_HIGH;
    end else if (ph == PH_EXEC) begin
      priority if (ix_in >= IDX_FIRST && ix_in < IDX_LAST_SETUP) begin
        hb_out = setup_byte(ix_in[1:0]);
        ix_out = ix_in + 3'd1;
        n = PH_HI_HIGH;
      end else if (ix_in == IDX_LAST_SETUP || ix_in == IDX_CLEAR) begin
        ix_out = IDX_NONE;
        n = PH_CLEARW;
      end else begin
        ix_out = IDX_NONE;
        n = PH_IDLE;
      end
    end else if (ph == PH_CLEARW || ph == PH_IDLE) begin
      n = PH_IDLE;
    end else begin
      n = phase_t'(5'(ph) + 5'd1);
    end
    return n;
  endfunction

  // next state: start or advance, then skip zero-length phases
  always_comb begin
    step_nxt = step_r;
    wait_nxt = wait_r;
    held_nxt = held_r;
    rs_nxt   = rs_r;
    en_nxt   = en_r;
    nib_nxt  = nib_r;
    idx_nxt  = idx_r;
    acc      = 1'b0;
    go       = 1'b0;
    p        = PH_IDLE;
    d        = '0;
    dc       = '0;
    ix_tmp   = '0;
    hb_tmp   = '0;
    if (step_en) begin
      if (item.action == ACT_TICK) begin
        if (step_r != PH_IDLE) begin
          if (wait_r > wait_t'(1)) begin
            wait_nxt = wait_r - wait_t'(1);
          end else begin
            go = 1'b1;
            p = next_phase(step_r, idx_r, held_r, ix_tmp, hb_tmp);
            idx_nxt = ix_tmp;
            held_nxt = hb_tmp;
          end
        end
      end else if (item.action <= ACT_CLEAR && step_r == PH_IDLE) begin
        acc = 1'b1;
        go = 1'b1;
        rs_nxt = 1'b0;
        idx_nxt = IDX_NONE;
        p = PH_HI_HIGH;
        unique case (item.action)
          ACT_INIT: p = PH_PWR;
          ACT_CMD: held_nxt = item.byte_value;
          ACT_DATA: begin
            rs_nxt = 1'b1;
            held_nxt = item.byte_value;
          end
          ACT_CURSOR:
            held_nxt = (item.row ? ROW1_BASE : ROW0_BASE) + 8'(item.col);
          default: begin
            held_nxt = CLEAR_CMD;
            idx_nxt = IDX_CLEAR;
          end
        endcase
      end
    end
    // a run of zero-length phases always ends within the four passes of this loop
    for (int i = 0; i < SKIP_STEPS; i++) begin
      if (go) begin
        step_nxt = p;
        if (p == PH_IDLE) begin
          wait_nxt = '0;
          go = 1'b0;
        end else begin
          d = phase_setup(p, held_nxt, cfg, ph_dur, en_nxt, nib_nxt);
          dc = clip_wait(d);
          if (dc != '0) begin
            wait_nxt = dc;
            go = 1'b0;
          end else begin
            p = next_phase(p, idx_nxt, held_nxt, ix_tmp, hb_tmp);
            idx_nxt = ix_tmp;
            held_nxt = hb_tmp;
          end
        end
      end
    end
  end

  // result fields reflect the state after this item
  always_comb begin
    res.rs_pin    = rs_nxt;
    res.en_pin    = en_nxt;
    res.data_pins = nib_nxt;
    res.busy_res  = (step_nxt != PH_IDLE);
    res.accepted  = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= PH_IDLE;
      wait_r <= '0;
      held_r <= '0;
      rs_r   <= 1'b0;
      en_r   <= 1'b0;
      nib_r  <= '0;
      idx_r  <= IDX_NONE;
    end else begin
      step_r <= step_nxt;
      wait_r <= wait_nxt;
      held_r <= held_nxt;
      rs_r   <= rs_nxt;
      en_r   <= en_nxt;
      nib_r  <= nib_nxt;
      idx_r  <= idx_nxt;
    end
  end

  a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == PH_IDLE |-> wait_r == '0)
    else $error("wait count left over in idle");

  a_busy_has_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != PH_IDLE |-> wait_r != '0)
    else $error("running phase with zero wait count");

  a_en_only_high: assert property (@(posedge clk) disable iff (!rst_n)
    en_r |-> (step_r == PH_I1_HIGH || step_r == PH_I2_HIGH || step_r == PH_I3_HIGH ||
              step_r == PH_I4_HIGH || step_r == PH_HI_HIGH || step_r == PH_LO_HIGH))
    else $error("enable high outside a pulse phase");

  a_idx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != IDX_NONE |-> step_r != PH_IDLE)
    else $error("init byte index set while idle");

endmodule

// ----- hw/rtl/char_lcd_4bit_sequencer.sv -----
// top level of the character display sequencer: stream ports, register file,
// input register and result register; depends on clcd_pkg and clcd_seq
// an input transfer goes to the input register, then the result register
// throughput: one item per cycle unless stalled; each worked in one pass
// reset: synchronous active-low rst_n clears the sequencer pin registers to low,
// sequencer to idle, registers to their defaults; no clearing pass
module char_lcd_4bit_sequencer
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // byte_value[7:0], row[8], col[14:9], zero pad
  input  logic [2:0]  in_tuser,   // action[2:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // rs_pin[0], en_pin[1], data_pins[5:2],
                                  // busy_res[6], accepted[7]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // register file
  cfg_t        cfg_r;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  // input register
  logic        s1_valid_r;
  item_t       s1_item_r;

  // result register
  logic        out_valid_r;
  res_t        out_res_r;

  logic        advance;
  logic        step_en;
  res_t        res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  // register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_up_wait   <= CFG_BITS'(20000);
      cfg_r.init_long_wait  <= CFG_BITS'(5000);
      cfg_r.init_short_wait <= CFG_BITS'(100);
      cfg_r.pulse_high      <= PULSE_BITS'(1);
      cfg_r.pulse_gap       <= CFG_BITS'(100);
      cfg_r.exec_wait       <= CFG_BITS'(40);
      cfg_r.clear_wait      <= CFG_BITS'(2000);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_POWER_UP:   cfg_r.power_up_wait   <= cfg_pwdata[CFG_BITS-1:0];
        REG_INIT_LONG:  cfg_r.init_long_wait  <= cfg_pwdata[CFG_BITS-1:0];
        REG_INIT_SHORT: cfg_r.init_short_wait <= cfg_pwdata[CFG_BITS-1:0];
        REG_PULSE_HIGH: cfg_r.pulse_high      <= cfg_pwdata[PULSE_BITS-1:0];
        REG_PULSE_GAP:  cfg_r.pulse_gap       <= cfg_pwdata[CFG_BITS-1:0];
        REG_EXEC_WAIT:  cfg_r.exec_wait       <= cfg_pwdata[CFG_BITS-1:0];
        REG_CLEAR_WAIT: cfg_r.clear_wait      <= cfg_pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_POWER_UP:   cfg_prdata = 32'(cfg_r.power_up_wait);
      REG_INIT_LONG:  cfg_prdata = 32'(cfg_r.init_long_wait);
      REG_INIT_SHORT: cfg_prdata = 32'(cfg_r.init_short_wait);
      REG_PULSE_HIGH: cfg_prdata = 32'(cfg_r.pulse_high);
      REG_PULSE_GAP:  cfg_prdata = 32'(cfg_r.pulse_gap);
      REG_EXEC_WAIT:  cfg_prdata = 32'(cfg_r.exec_wait);
      REG_CLEAR_WAIT: cfg_prdata = 32'(cfg_r.clear_wait);
      default:        cfg_prdata = '0;
    endcase
  end

  // the held item moves on whenever the result register is free or drains
  assign advance   = !out_valid_r || out_tready;
  assign step_en   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload of the input register, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.action     <= in_tuser;
      s1_item_r.byte_value <= in_tdata[7:0];
      s1_item_r.row        <= in_tdata[8];
      s1_item_r.col        <= in_tdata[14:9];
    end
  end

  // sequencer state advances once per worked item
  clcd_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  // an accepted request always leaves a phase running
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.accepted |-> out_res_r.busy_res)
    else $error("accepted request reported idle");

  // a stalled result register keeps the held item waiting
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready && s1_valid_r |=> s1_valid_r)
    else $error("held item lost during stall");

  // an item worked from the input register always reaches the result register
  a_worked: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("worked item produced no result");

endmodule

// ----- tb/tb_char_lcd_4bit_sequencer.sv -----
// self-checking testbench for the character display sequencer: a directed table,
// then randomized request and tick streams checked against a built-in pin predictor
// depends on clcd_pkg and the char_lcd_4bit_sequencer rtl
module tb_char_lcd_4bit_sequencer;
  import clcd_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
  localparam int MAX_GAP       = 19;
  localparam int SETTLE_CYCLES = 4;     // extra margin once every result is back
  localparam int REPORT_LINES  = 50;    // keep the log readable when everything breaks
  localparam int RESET_ROWS    = 6;
  localparam int NUM_ROWS      = 21;
  localparam int RANDOM_PHASES = 8;

  // actions the block must ignore
  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  localparam logic [7:0] INIT_BYTES [4] = '{8'h28, 8'h0C, 8'h06, CLEAR_CMD};

  typedef enum int {GAP_NONE, GAP_FULL, GAP_SPARSE} gap_mode_t;

  // one row of the directed table: settle first, item, and a typed result if any
  typedef struct packed {
    logic  settle;
    item_t it;
    logic  typed;
    res_t  want;
  } dir_row_t;

  function automatic item_t req(input logic [2:0] action, input logic [7:0] b,
                                input logic row, input logic [5:0] col);
    item_t it;
    it.action     = action;
    it.byte_value = b;
    it.row        = row;
    it.col        = col;
    return it;
  endfunction

  function automatic res_t pins(input logic rs, input logic en, input logic [3:0] nib,
                                input logic busy, input logic acc);
    res_t r;
    r.rs_pin    = rs;
    r.en_pin    = en;
    r.data_pins = nib;
    r.busy_res  = busy;
    r.accepted  = acc;
    return r;
  endfunction

  function automatic dir_row_t row(input logic settle, input item_t it,
                                   input logic typed, input res_t want);
    dir_row_t d;
    d.settle = settle;
    d.it     = it;
    d.typed  = typed;
    d.want   = want;
    return d;
  endfunction

  // first rows run with the reset register values, the rest with a short timing set
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    // idle tick and undefined actions leave every pin low
    row(1'b0, req(ACT_TICK, 8'h00, 1'b0, 6'd0), 1'b1, pins(1'b0, 1'b0, 4'h0, 1'b0, 1'b0)),
    row(1'b0, req(ACT_UNUSED_LO, 8'hFF, 1'b1, 6'd63), 1'b1,
        pins(1'b0, 1'b0, 4'h0, 1'b0, 1'b0)),
    row(1'b0, req(ACT_UNUSED_HI, 8'h00, 1'b0, 6'd0), 1'b1, pins(1'b0, 1'b0, 4'h0, 1'b0, 1'b0)),
    // command byte puts its high nibble out at once
    row(1'b0, req(ACT_CMD, 8'hFF, 1'b0, 6'd0), 1'b1, pins(1'b0, 1'b1, 4'hF, 1'b1, 1'b1)),
    // refused while busy, pins unchanged
    row(1'b0, req(ACT_DATA, 8'h00, 1'b1, 6'd63), 1'b1, pins(1'b0, 1'b1, 4'hF, 1'b1, 1'b0)),
    row(1'b0, req(ACT_TICK, 8'hFF, 1'b1, 6'd63), 1'b0, '0),
    // short timing set from here on
    row(1'b1, req(ACT_INIT, 8'h5A, 1'b0, 6'd0), 1'b0, '0),
    row(1'b0, req(ACT_CURSOR, 8'h00, 1'b1, 6'd5), 1'b0, '0),
    row(1'b0, req(ACT_TICK, 8'h00, 1'b0, 6'd0), 1'b0, '0),
    row(1'b1, req(ACT_CLEAR, 8'hFF, 1'b1, 6'd63), 1'b0, '0),
    // cursor addresses: first line base, and each line base plus the widest column
    row(1'b1, req(ACT_CURSOR, 8'hFF, 1'b0, 6'd0), 1'b1, pins(1'b0, 1'b1, 4'h8, 1'b1, 1'b1)),
    row(1'b1, req(ACT_CURSOR, 8'h00, 1'b1, 6'd63), 1'b1, pins(1'b0, 1'b1, 4'hF, 1'b1, 1'b1)),
    row(1'b1, req(ACT_CURSOR, 8'h00, 1'b0, 6'd63), 1'b1, pins(1'b0, 1'b1, 4'hB, 1'b1, 1'b1)),
    // clear code sent as a plain command gets no clear wait
    row(1'b1, req(ACT_CMD, CLEAR_CMD, 1'b0, 6'd0), 1'b0, '0),
    row(1'b1, req(ACT_DATA, 8'h00, 1'b0, 6'd0), 1'b1, pins(1'b1, 1'b1, 4'h0, 1'b1, 1'b1)),
    row(1'b1, req(ACT_DATA, 8'hFF, 1'b1, 6'd63), 1'b1, pins(1'b1, 1'b1, 4'hF, 1'b1, 1'b1)),
    row(1'b1, req(ACT_DATA, 8'hA5, 1'b0, 6'd21), 1'b0, '0),
    row(1'b0, req(ACT_UNUSED_HI, 8'hFF, 1'b1, 6'd63), 1'b0, '0),
    row(1'b0, req(ACT_CMD, 8'h3C, 1'b0, 6'd42), 1'b0, '0),
    row(1'b1, req(ACT_INIT, 8'h00, 1'b1, 6'd0), 1'b0, '0),
    row(1'b0, req(ACT_TICK, 8'h00, 1'b0, 6'd0), 1'b0, '0)
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;      // byte_value[7:0], row[8], col[14:9], zero pad
  logic [2:0]  in_tuser = ACT_TICK; // action[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // rs_pin[0], en_pin[1], data_pins[5:2],
                                   // busy_res[6], accepted[7]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  char_lcd_4bit_sequencer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // pin predictor: shadow registers plus its own copy of the sequencer state
  // ---------------------------------------------------------------------------
  cfg_t           lcd_cfg;
  phase_t         pr_phase;
  wait_t          pr_wait;
  logic [7:0]     pr_byte;
  logic           pr_rs;
  logic           pr_en;
  logic [3:0]     pr_nib;
  logic [2:0]     pr_idx;

  res_t           pins_due_q [$];  // expected pin states, oldest first
  int             mismatch_count = 0;
  int             result_count = 0;
  gap_mode_t      gap_mode = GAP_NONE;

  function automatic void raise_en(input logic [3:0] nib);
    pr_nib = nib;
    pr_en  = 1'b1;
  endfunction

  // drive the pins that a phase sets on entry and return how long it lasts
  function automatic logic [31:0] phase_ticks(input phase_t p);
    logic [31:0] hi;
    hi = (lcd_cfg.pulse_high == '0) ? 32'd1 : 32'(lcd_cfg.pulse_high);
    case (p)
      PH_PWR: return 32'(lcd_cfg.power_up_wait);
      PH_I1_HIGH, PH_I2_HIGH, PH_I3_HIGH: begin
        raise_en(NIB_INIT);
        return hi;
      end
      PH_I4_HIGH: begin
        raise_en(NIB_FOUR_BIT);
        return hi;
      end
      PH_HI_HIGH: begin
        raise_en(pr_byte[7:4]);
        return hi;
      end
      PH_LO_HIGH: begin
        raise_en(pr_byte[3:0]);
        return hi;
      end
      PH_I1_GAP, PH_I2_GAP, PH_I3_GAP, PH_I4_GAP, PH_HI_GAP, PH_LO_GAP: begin
        pr_en = 1'b0;
        return 32'(lcd_cfg.pulse_gap);
      end
      PH_I1_WAIT: return 32'(lcd_cfg.init_long_wait);
      PH_I2_WAIT, PH_I3_WAIT: return 32'(lcd_cfg.init_short_wait);
      PH_EXEC: return 32'(lcd_cfg.exec_wait);
      PH_CLEARW: return 32'(lcd_cfg.clear_wait);
      default: return 32'd0;
    endcase
  endfunction

  // phase that follows p; init walks through its setup bytes, clear adds its wait
  function automatic phase_t follow_phase(input phase_t p);
    if (p == PH_I4_GAP) begin
      pr_idx  = IDX_FIRST;
      pr_byte = INIT_BYTES[0];
      return PH_HI_HIGH;
    end
    if (p == PH_EXEC) begin
      if (pr_idx >= IDX_FIRST && pr_idx < IDX_LAST_SETUP) begin
        pr_byte = INIT_BYTES[pr_idx[1:0]];
        pr_idx  = pr_idx + 3'd1;
        return PH_HI_HIGH;
      end
      if (pr_idx == IDX_LAST_SETUP || pr_idx == IDX_CLEAR) begin
        pr_idx = IDX_NONE;
        return PH_CLEARW;
      end
      pr_idx = IDX_NONE;
      return PH_IDLE;
    end
    if (p >= PH_CLEARW) return PH_IDLE;
    return phase_t'(p + 1);
  endfunction

  // enter p, skipping every phase of zero length on the way
  function automatic void start_phase(input phase_t p);
    logic [31:0] d;
    phase_t      q;
    bit          done;
    q    = p;
    done = 1'b0;
    while (!done) begin
      pr_phase = q;
      if (q == PH_IDLE) begin
        pr_wait = '0;
        done    = 1'b1;
      end else begin
        d = phase_ticks(q);
        if (d > 32'({WAIT_BITS{1'b1}})) d = 32'({WAIT_BITS{1'b1}});
        if (d != 32'd0) begin
          pr_wait = wait_t'(d);
          done    = 1'b1;
        end else begin
          q = follow_phase(q);
        end
      end
    end
  endfunction

  // apply one item and return the pin state the block should show afterwards
  function automatic res_t next_pins(input item_t it);
    logic acc;
    acc = 1'b0;
    if (it.action == ACT_TICK) begin
      if (pr_phase != PH_IDLE) begin
        if (pr_wait > wait_t'(1)) pr_wait = pr_wait - wait_t'(1);
        else start_phase(follow_phase(pr_phase));
      end
    end else if (it.action <= ACT_CLEAR && pr_phase == PH_IDLE) begin
      acc    = 1'b1;
      pr_rs  = (it.action == ACT_DATA);
      pr_idx = IDX_NONE;
      case (it.action)
        ACT_CMD, ACT_DATA: pr_byte = it.byte_value;
        ACT_CURSOR: pr_byte = (it.row ? ROW1_BASE : ROW0_BASE) + {2'b00, it.col};
        ACT_CLEAR: begin
          pr_byte = CLEAR_CMD;
          pr_idx  = IDX_CLEAR;
        end
        default: ;
      endcase
      start_phase((it.action == ACT_INIT) ? PH_PWR : PH_HI_HIGH);
    end
    return pins(pr_rs, pr_en, pr_nib, pr_phase != PH_IDLE, acc);
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      REG_POWER_UP:   lcd_cfg.power_up_wait   = v[15:0];
      REG_INIT_LONG:  lcd_cfg.init_long_wait  = v[15:0];
      REG_INIT_SHORT: lcd_cfg.init_short_wait = v[15:0];
      REG_PULSE_HIGH: lcd_cfg.pulse_high      = v[7:0];
      REG_PULSE_GAP:  lcd_cfg.pulse_gap       = v[15:0];
      REG_EXEC_WAIT:  lcd_cfg.exec_wait       = v[15:0];
      REG_CLEAR_WAIT: lcd_cfg.clear_wait      = v[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_POWER_UP:   return 32'(lcd_cfg.power_up_wait);
      REG_INIT_LONG:  return 32'(lcd_cfg.init_long_wait);
      REG_INIT_SHORT: return 32'(lcd_cfg.init_short_wait);
      REG_PULSE_HIGH: return 32'(lcd_cfg.pulse_high);
      REG_PULSE_GAP:  return 32'(lcd_cfg.pulse_gap);
      REG_EXEC_WAIT:  return 32'(lcd_cfg.exec_wait);
      REG_CLEAR_WAIT: return 32'(lcd_cfg.clear_wait);
      default: return 32'd0;
    endcase
  endfunction

  function automatic int pick_gap();
    case (gap_mode)
      GAP_FULL:   return $urandom_range(0, MAX_GAP);
      GAP_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
      default:    return 0;
    endcase
  endfunction

  // mostly well-formed traffic: requests when idle, ticks while a sequence runs,
  // with some refused requests and ignored actions mixed in
  function automatic item_t draw_item();
    item_t it;
    int    pick;
    it.byte_value = 8'($urandom);
    it.row        = 1'($urandom);
    it.col        = 6'($urandom);
    pick          = $urandom_range(0, 99);
    if (pr_phase == PH_IDLE) begin
      if (pick < 5)       it.action = ACT_INIT;
      else if (pick < 30) it.action = ACT_CMD;
      else if (pick < 50) it.action = ACT_DATA;
      else if (pick < 65) it.action = ACT_CURSOR;
      else if (pick < 72) it.action = ACT_CLEAR;
      else if (pick < 92) it.action = ACT_TICK;
      else                it.action = (pick < 96) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
    end else begin
      if (pick < 85)      it.action = ACT_TICK;
      else if (pick < 95) it.action = 3'($urandom_range(ACT_INIT, ACT_CLEAR));
      else                it.action = (pick < 98) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
    end
    return it;
  endfunction

  function automatic logic [15:0] draw_wait();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40))
                                       : 16'($urandom_range(0, 4));
  endfunction

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one item after a random gap and record what it should produce;
  // tvalid stays high afterwards until the next gap or drain
  task automatic send(input item_t it, input logic typed, input res_t want);
    int   gap;
    res_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, it.col, it.row, it.byte_value};
    in_tuser  <= it.action;
    do @(posedge clk); while (in_tready !== 1'b1);
    got = next_pins(it);
    pins_due_q.push_back(typed ? want : got);
  endtask

  // tick until the predicted sequence is over
  task automatic flush_to_idle();
    item_t t;
    while (pr_phase != PH_IDLE) begin
      t = req(ACT_TICK, 8'($urandom), 1'($urandom), 6'($urandom));
      send(t, 1'b0, '0);
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pins_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // configuration bus
  // ---------------------------------------------------------------------------
  task automatic cfg_access(input logic wr, input logic [2:0] idx, input logic [31:0] v,
                            output logic [31:0] rd);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rd          = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [31:0] rd;
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx))
      report($sformatf("register %0d reads %0h, want %0h", idx, rd, reg_value(idx)));
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
    logic [31:0] rd;
    store_reg(idx, v);
    cfg_access(1'b1, idx, v, rd);
    check_reg(idx);
  endtask

  // only called with the block idle and nothing outstanding
  task automatic apply_settings(input logic [15:0] pwr, input logic [15:0] lng,
                                input logic [15:0] sht, input logic [7:0] hi,
                                input logic [15:0] gap, input logic [15:0] exe,
                                input logic [15:0] clr);
    cfg_write(REG_POWER_UP, 32'(pwr));
    cfg_write(REG_INIT_LONG, 32'(lng));
    cfg_write(REG_INIT_SHORT, 32'(sht));
    cfg_write(REG_PULSE_HIGH, 32'(hi));
    cfg_write(REG_PULSE_GAP, 32'(gap));
    cfg_write(REG_EXEC_WAIT, 32'(exe));
    cfg_write(REG_CLEAR_WAIT, 32'(clr));
  endtask

  task automatic run_rows(input int lo, input int hi);
    for (int i = lo; i < hi; i++) begin
      if (DIR_ROWS[i].settle) flush_to_idle();
      send(DIR_ROWS[i].it, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end
  endtask

  task automatic random_phase(input int n_items);
    item_t it;
    int    sent;
    sent = 0;
    while (sent < n_items) begin
      // change idling style now and then so bursts and gappy stretches both occur
      if (sent % 50 == 0) gap_mode = gap_mode_t'($urandom_range(GAP_NONE, GAP_SPARSE));
      // occasionally hold the input until every result is back
      if ($urandom_range(0, 199) == 0) wait_drained();
      it = draw_item();
      send(it, 1'b0, '0);
      if (it.action <= ACT_CLEAR) sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls on out_tready, compare each transfer in order
  // ---------------------------------------------------------------------------
  initial begin
    res_t got;
    res_t want;
    int   stall;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got = res_t'(out_tdata);
      result_count++;
      if (pins_due_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = pins_due_q.pop_front();
        if (got.rs_pin !== want.rs_pin)
          report($sformatf("result %0d rs_pin %b, want %b", result_count,
                           got.rs_pin, want.rs_pin));
        if (got.en_pin !== want.en_pin)
          report($sformatf("result %0d en_pin %b, want %b", result_count,
                           got.en_pin, want.en_pin));
        if (got.data_pins !== want.data_pins)
          report($sformatf("result %0d data_pins %h, want %h", result_count,
                           got.data_pins, want.data_pins));
        if (got.busy_res !== want.busy_res)
          report($sformatf("result %0d busy_res %b, want %b", result_count,
                           got.busy_res, want.busy_res));
        if (got.accepted !== want.accepted)
          report($sformatf("result %0d accepted %b, want %b", result_count,
                           got.accepted, want.accepted));
      end
    end
  end

  // watchdog: give up when neither stream moves for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("stream stalled for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    lcd_cfg = '{power_up_wait: 16'd20000, init_long_wait: 16'd5000,
                init_short_wait: 16'd100, pulse_high: 8'd1, pulse_gap: 16'd100,
                exec_wait: 16'd40, clear_wait: 16'd2000};
    pr_phase = PH_IDLE;
    pr_wait  = '0;
    pr_byte  = '0;
    pr_rs    = 1'b0;
    pr_en    = 1'b0;
    pr_nib   = '0;
    pr_idx   = IDX_NONE;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults after reset
    check_reg(REG_POWER_UP);
    check_reg(REG_INIT_LONG);
    check_reg(REG_INIT_SHORT);
    check_reg(REG_PULSE_HIGH);
    check_reg(REG_PULSE_GAP);
    check_reg(REG_EXEC_WAIT);
    check_reg(REG_CLEAR_WAIT);

    // directed table, first with reset timing, then with a short set that
    // has zero-length gaps and exec waits and a zero pulse width
    gap_mode = GAP_SPARSE;
    run_rows(0, RESET_ROWS);
    flush_to_idle();
    wait_drained();
    apply_settings(16'd3, 16'd2, 16'd1, 8'd0, 16'd0, 16'd0, 16'd2);
    run_rows(RESET_ROWS, NUM_ROWS);
    flush_to_idle();
    wait_drained();

    // every register at its low end
    apply_settings(16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    random_phase(150);
    flush_to_idle();
    wait_drained();

    // every register at its high end; then one byte runs the widest pulse
    // with short gaps and exec wait so the tick count stays modest
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    cfg_write(REG_PULSE_GAP, 32'd3);
    cfg_write(REG_EXEC_WAIT, 32'd2);
    gap_mode = GAP_NONE;
    send(req(ACT_DATA, 8'h5A, 1'b1, 6'd33), 1'b0, '0);
    flush_to_idle();
    wait_drained();

    // random register sets, mostly short so sequences complete often
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(draw_wait(), draw_wait(), draw_wait(),
                     ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 3)),
                     draw_wait(), draw_wait(), draw_wait());
      random_phase(220);
      flush_to_idle();
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
